// ===== sv/aik_pkg.sv =====
package aik_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_SHIFT    = 30 - FRAC_BITS;
    localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

    localparam int XW      = 17;
    localparam int LW      = 16;
    localparam int ZW      = 18;
    localparam int MW      = 19;
    localparam int PW      = 2 * MW;
    localparam int AW      = 40;
    localparam int CW      = 18;
    localparam int SW      = 17;
    localparam int RT_W    = 18;
    localparam int DENW    = 35;
    localparam int DS_W    = 52;
    localparam int RES_W   = 34;
    localparam int DS_STEPS = 17;
    localparam int SQ_TOP_BIT = 32;
    localparam int CIN_W   = 36;
    localparam int CX_W    = 34;
    localparam int CACC_W  = 35;
    localparam int ANG_W   = 21;
    localparam int TH_W    = 24;
    localparam int JW      = 20;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 17;

    localparam logic [CFG_AW-1:0] CFG_L1   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_L2   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SH   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PHI  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RL   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_HL   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_ZMIN = 3'd6;

    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_ACCEPT = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    localparam logic DS_SQRT = 1'b0;
    localparam logic DS_DIV  = 1'b1;

    localparam logic [LW-1:0] RST_L1  = 16'd15644;
    localparam logic [LW-1:0] RST_L2  = 16'd14155;
    localparam logic [LW-1:0] RST_SH  = 16'd2488;
    localparam logic [LW-1:0] RST_PHI = 16'd8258;
    localparam logic [LW-1:0] RST_RL  = 16'd32113;
    localparam logic [LW-1:0] RST_HL  = 16'd26214;
    localparam logic signed [XW-1:0] RST_ZMIN = -17'sd11667;
    localparam logic signed [XW-1:0] RST_SZ   = 17'sd32162;

    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint SH_LIM_Q30  = 64'd1686629362;
    localparam longint EL_LO_Q30   = 64'd843314842;
    localparam longint EL_HI_Q30   = 64'd3373259369;
    localparam longint RND         = 64'd1 << (ANG_SHIFT - 1);

    localparam longint HALF_PI_F = (HALF_PI_Q30 + RND) >>> ANG_SHIFT;
    localparam longint SH_LIM_F  = (SH_LIM_Q30 + RND) >>> ANG_SHIFT;
    localparam longint EL_LO_F   = (EL_LO_Q30 + RND) >>> ANG_SHIFT;
    localparam longint EL_HI_F   = (EL_HI_Q30 + RND) >>> ANG_SHIFT;
    localparam longint ONE_F     = 64'd1 << FRAC_BITS;

    localparam longint OUT_MAX = 64'd524287;
    localparam longint OUT_MIN = -64'sd524288;

    typedef struct packed {
        logic            start;
        logic            mode;
        logic [DS_W-1:0] num;
        logic [DS_W-1:0] dvs;
    } ds_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [CIN_W-1:0] y;
        logic signed [CIN_W-1:0] x;
    } cor_req_t;

    function automatic logic [30:0] atan_step(input logic [STEP_W-1:0] i);
        logic [30:0] v;
        case (i)
            0:       v = 31'd843314857;
            1:       v = 31'd497837829;
            2:       v = 31'd263043837;
            3:       v = 31'd133525159;
            4:       v = 31'd67021687;
            5:       v = 31'd33543516;
            6:       v = 31'd16775851;
            7:       v = 31'd8388437;
            8:       v = 31'd4194283;
            9:       v = 31'd2097149;
            10:      v = 31'd1048576;
            default: v = (int'(i) <= 30) ? (31'd1 << (30 - int'(i))) : '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] q30_to_frac(
        input logic signed [CACC_W-1:0] a);
        logic signed [CACC_W-1:0] s;
        s = a + CACC_W'(RND);
        return ANG_W'(s >>> ANG_SHIFT);
    endfunction

    function automatic logic signed [JW-1:0] sat20(input logic signed [TH_W-1:0] v);
        logic signed [JW-1:0] r;
        if (v > TH_W'(OUT_MAX))
            r = JW'(OUT_MAX);
        else if (v < TH_W'(OUT_MIN))
            r = JW'(OUT_MIN);
        else
            r = JW'(v);
        return r;
    endfunction

endpackage

// ===== sv/aik_if.sv =====
interface aik_in_if;
    import aik_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic signed [XW-1:0] target_x;
    logic signed [XW-1:0] target_y;
    logic signed [XW-1:0] target_z;

    modport source (output valid, action, target_x, target_y, target_z, input ready);
    modport sink   (input valid, action, target_x, target_y, target_z, output ready);
endinterface

interface aik_out_if;
    import aik_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [JW-1:0] joint_base;
    logic signed [JW-1:0] joint_shoulder;
    logic signed [JW-1:0] joint_elbow;
    logic signed [JW-1:0] joint_wrist;

    modport source (output valid, status, joint_base, joint_shoulder, joint_elbow,
                    joint_wrist, input ready);
    modport sink   (input valid, status, joint_base, joint_shoulder, joint_elbow,
                    joint_wrist, output ready);
endinterface

// ===== sv/aik_divsqrt.sv =====
module aik_divsqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  aik_pkg::ds_req_t        req,
    output logic                    done,
    output logic [aik_pkg::RT_W-1:0] result
);
    import aik_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;
    localparam int CNT_W = $clog2(DS_STEPS);

    logic [1:0]       state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [DS_W-1:0]  rem_reg, rem_next;
    logic [DS_W-1:0]  aux_reg, aux_next;
    logic [RES_W-1:0] res_reg, res_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DS_W-1:0]  cmp;
    logic             ge;

    assign cmp = (mode_reg == DS_DIV) ? aux_reg : (DS_W'(res_reg) + aux_reg);
    assign ge  = rem_reg >= cmp;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        aux_next   = aux_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    mode_next = req.mode;
                    rem_next  = req.num;
                    aux_next  = (req.mode == DS_DIV) ? (req.dvs << (DS_STEPS - 1))
                                                     : (DS_W'(1) << SQ_TOP_BIT);
                    res_next  = '0;
                    cnt_next  = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                if (ge)
                    rem_next = rem_reg - cmp;
                if (mode_reg == DS_DIV)
                begin
                    res_next = {res_reg[RES_W-2:0], ge};
                    aux_next = aux_reg >> 1;
                end
                else
                begin
                    res_next = ge ? ((res_reg >> 1) + RES_W'(aux_reg)) : (res_reg >> 1);
                    aux_next = aux_reg >> 2;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DS_STEPS - 1))
                    state_next = D_FIN;
            end
            D_FIN:
            begin
                if (mode_reg == DS_SQRT && rem_reg > DS_W'(res_reg))
                    res_next = res_reg + 1'b1;
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        rem_reg  <= rem_next;
        aux_reg  <= aux_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg[RT_W-1:0];

endmodule

// ===== sv/aik_cordic.sv =====
module aik_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aik_pkg::cor_req_t                req,
    output logic                             done,
    output logic signed [aik_pkg::ANG_W-1:0] angle
);
    import aik_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_NORM = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]                state_reg, state_next;
    logic [CIN_W-1:0]          ux_reg, ux_next, uy_reg, uy_next;
    logic                      neg_reg, neg_next;
    logic signed [CX_W-1:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CACC_W-1:0]  acc_reg, acc_next;
    logic [STEP_W-1:0]         i_reg, i_next;
    logic                      done_reg, done_next;
    logic signed [ANG_W-1:0]   angle_reg, angle_next;

    logic signed [CIN_W-1:0]   fx, fy;
    logic [CIN_W-1:0]          m;
    logic signed [CX_W-1:0]    sx, sy;
    logic signed [CACC_W-1:0]  stp;

    assign m   = (ux_reg > uy_reg) ? ux_reg : uy_reg;
    assign sx  = cx_reg >>> i_reg;
    assign sy  = cy_reg >>> i_reg;
    assign stp = $signed({{(CACC_W-31){1'b0}}, atan_step(i_reg)});
    assign fx  = req.x[CIN_W-1] ? -req.x : req.x;
    assign fy  = req.x[CIN_W-1] ? -req.y : req.y;

    always_comb
    begin
        state_next = state_reg;
        ux_next    = ux_reg;
        uy_next    = uy_reg;
        neg_next   = neg_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        acc_next   = acc_reg;
        i_next     = i_reg;
        angle_next = angle_reg;
        done_next  = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    if (req.x[CIN_W-1])
                        acc_next = req.y[CIN_W-1] ? -CACC_W'(PI_Q30) : CACC_W'(PI_Q30);
                    else
                        acc_next = '0;
                    neg_next = fy[CIN_W-1];
                    ux_next  = fx;
                    uy_next  = fy[CIN_W-1] ? -fy : fy;
                    if (fx == '0 && fy == '0)
                        state_next = C_FIN;
                    else
                        state_next = C_NORM;
                end
            end
            C_NORM:
            begin
                if (m > (CIN_W'(1) << 30))
                begin
                    ux_next = ux_reg >> 1;
                    uy_next = uy_reg >> 1;
                end
                else if (m < (CIN_W'(1) << 29))
                begin
                    ux_next = ux_reg << 1;
                    uy_next = uy_reg << 1;
                end
                else
                begin
                    cx_next = $signed(ux_reg[CX_W-1:0]);
                    cy_next = neg_reg ? -$signed(uy_reg[CX_W-1:0])
                                      : $signed(uy_reg[CX_W-1:0]);
                    i_next  = '0;
                    state_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (cy_reg == '0 || i_reg == STEP_W'(CORDIC_STEPS))
                    state_next = C_FIN;
                else
                begin
                    if (cy_reg > 0)
                    begin
                        cx_next  = cx_reg + sy;
                        cy_next  = cy_reg - sx;
                        acc_next = acc_reg + stp;
                    end
                    else
                    begin
                        cx_next  = cx_reg - sy;
                        cy_next  = cy_reg + sx;
                        acc_next = acc_reg - stp;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            C_FIN:
            begin
                angle_next = q30_to_frac(acc_reg);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg    <= ux_next;
        uy_reg    <= uy_next;
        neg_reg   <= neg_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        acc_reg   <= acc_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// ===== sv/arm_inverse_kinematics_core.sv =====
// Two-link arm inverse kinematics. A set-target word (action 0) is checked against the
// workspace box and reach sphere, stored if it passes, and answered with status accepted
// or rejected. A tick word (action 1) turns the stored target into base, shoulder,
// elbow and wrist angles (Q.16 radians) with one 19x19 multiply-accumulate per step
// for the sums of squares, then the shared 17-step divide/square-root unit up to three
// times (the divide is skipped when the cosine saturates), then the shared CORDIC unit
// four times (up to 29 normalizing shifts plus up to 16 rotations each), which takes
// most of the time.
// The input is ready only while no word is in progress; a finished result waits in the
// output register until taken. Configuration writes take effect at once.
module arm_inverse_kinematics_core (
    input  logic                         clk,
    input  logic                         rst_n,
    aik_in_if.sink                       din,
    aik_out_if.source                    dout,
    input  logic                         cfg_we,
    input  logic [aik_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [aik_pkg::CFG_DW-1:0]   cfg_wdata
);
    import aik_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_SXX  = 5'd1;
    localparam logic [4:0] ST_SYY  = 5'd2;
    localparam logic [4:0] ST_SZZ  = 5'd3;
    localparam logic [4:0] ST_SCMP = 5'd4;
    localparam logic [4:0] ST_TXX  = 5'd5;
    localparam logic [4:0] ST_TYY  = 5'd6;
    localparam logic [4:0] ST_TZZ  = 5'd7;
    localparam logic [4:0] ST_TL1  = 5'd8;
    localparam logic [4:0] ST_TL2  = 5'd9;
    localparam logic [4:0] ST_TDEN = 5'd10;
    localparam logic [4:0] ST_TCSEL = 5'd11;
    localparam logic [4:0] ST_TDIV = 5'd12;
    localparam logic [4:0] ST_TCC  = 5'd13;
    localparam logic [4:0] ST_TSQS = 5'd14;
    localparam logic [4:0] ST_TSQR = 5'd15;
    localparam logic [4:0] ST_TBY  = 5'd16;
    localparam logic [4:0] ST_TBX  = 5'd17;
    localparam logic [4:0] ST_TCST = 5'd18;
    localparam logic [4:0] ST_TCW  = 5'd19;
    localparam logic [4:0] ST_OUT  = 5'd20;

    localparam logic [1:0] ANG_ALPHA = 2'd0;
    localparam logic [1:0] ANG_BETA  = 2'd1;
    localparam logic [1:0] ANG_T3    = 2'd2;
    localparam logic [1:0] ANG_BASE  = 2'd3;

    logic [4:0] state_reg, state_next;

    logic [LW-1:0]        l1_reg, l2_reg, sh_reg, phi_reg, rl_reg, hl_reg;
    logic signed [XW-1:0] zmin_reg;

    logic signed [XW-1:0] st_x_reg, st_x_next, st_y_reg, st_y_next, st_z_reg, st_z_next;
    logic                 act_reg, act_next;
    logic signed [XW-1:0] in_x_reg, in_x_next, in_y_reg, in_y_next, in_z_reg, in_z_next;
    logic                 ok_reg, ok_next;

    logic signed [AW-1:0]    acc_reg, acc_next;
    logic [RES_W-1:0]        rr_reg, rr_next;
    logic [DENW-1:0]         den_reg, den_next;
    logic signed [CW-1:0]    c_reg, c_next;
    logic [SW-1:0]           s_reg, s_next;
    logic [RT_W-1:0]         r_reg, r_next;
    logic signed [CIN_W-1:0] by_reg, by_next, bx_reg, bx_next;
    logic [1:0]              idx_reg, idx_next;
    logic signed [ANG_W-1:0] ang_reg [4];
    logic signed [ANG_W-1:0] ang_wdata;
    logic                    ang_we;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic signed [JW-1:0] jb_reg, jb_next, js_reg, js_next, je_reg, je_next;
    logic signed [JW-1:0] jw_reg, jw_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;
    logic signed [ZW-1:0] zt;
    logic [AW-1:0]        mag;
    logic                 box_ok;
    logic                 slot_free;

    ds_req_t              ds_req;
    logic                 ds_done;
    logic [RT_W-1:0]      ds_result;
    cor_req_t             cor_req;
    logic                 cor_done;
    logic signed [ANG_W-1:0] cor_angle;

    logic signed [TH_W-1:0] phi_s, alpha, beta, t3, th2_0, th2_1, th3_0, th3_1;
    logic signed [TH_W-1:0] fs, fe;

    aik_divsqrt u_ds (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (ds_req),
        .done   (ds_done),
        .result (ds_result)
    );

    aik_cordic u_cor (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .done  (cor_done),
        .angle (cor_angle)
    );

    assign zt   = ZW'(st_z_reg) - $signed({2'b00, sh_reg});
    assign prod = mul_a * mul_b;
    assign mag  = acc_reg[AW-1] ? AW'(-acc_reg) : AW'(acc_reg);
    assign slot_free = !out_valid_reg || dout.ready;

    assign box_ok = !in_x_reg[XW-1]
                 && ($signed({in_x_reg[XW-1], in_x_reg}) <= $signed({2'b00, hl_reg}))
                 && ($signed({in_y_reg[XW-1], in_y_reg}) <= $signed({2'b00, hl_reg}))
                 && ($signed({in_y_reg[XW-1], in_y_reg}) >= -$signed({2'b00, hl_reg}))
                 && (in_z_reg >= zmin_reg)
                 && ($signed({in_z_reg[XW-1], in_z_reg}) <= $signed({2'b00, rl_reg}));

    always_comb
    begin
        case (state_reg)
            ST_SXX:  begin mul_a = MW'(in_x_reg); mul_b = MW'(in_x_reg); end
            ST_SYY:  begin mul_a = MW'(in_y_reg); mul_b = MW'(in_y_reg); end
            ST_SZZ:  begin mul_a = MW'(in_z_reg); mul_b = MW'(in_z_reg); end
            ST_SCMP: begin mul_a = $signed({3'b000, rl_reg}); mul_b = $signed({3'b000, rl_reg}); end
            ST_TXX:  begin mul_a = MW'(st_x_reg); mul_b = MW'(st_x_reg); end
            ST_TYY:  begin mul_a = MW'(st_y_reg); mul_b = MW'(st_y_reg); end
            ST_TZZ:  begin mul_a = MW'(zt); mul_b = MW'(zt); end
            ST_TL1:  begin mul_a = $signed({3'b000, l1_reg}); mul_b = $signed({3'b000, l1_reg}); end
            ST_TL2:  begin mul_a = $signed({3'b000, l2_reg}); mul_b = $signed({3'b000, l2_reg}); end
            ST_TDEN: begin mul_a = $signed({3'b000, l1_reg}); mul_b = $signed({3'b000, l2_reg}); end
            ST_TCC:  begin mul_a = MW'(c_reg); mul_b = MW'(c_reg); end
            ST_TBY:  begin mul_a = $signed({3'b000, l2_reg}); mul_b = $signed({2'b00, s_reg}); end
            ST_TBX:  begin mul_a = $signed({3'b000, l2_reg}); mul_b = MW'(c_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        phi_s = $signed({{(TH_W-LW){1'b0}}, phi_reg});
        alpha = TH_W'(ang_reg[ANG_ALPHA]);
        beta  = TH_W'(ang_reg[ANG_BETA]);
        t3    = TH_W'(ang_reg[ANG_T3]);
        th2_0 = TH_W'(HALF_PI_F) - (alpha - beta + phi_s);
        th2_1 = TH_W'(HALF_PI_F) - (alpha + beta + phi_s);
        th3_0 = phi_s - t3;
        th3_1 = phi_s + t3;
        fs = '0;
        fe = '0;
        if (th2_0 >= -TH_W'(SH_LIM_F) && th2_0 <= TH_W'(SH_LIM_F))
        begin
            fs = th2_0;
            if (th3_0 >= -TH_W'(EL_LO_F) && th3_0 <= TH_W'(EL_HI_F))
                fe = th3_0;
        end
        if (th2_1 >= -TH_W'(SH_LIM_F) && th2_1 <= TH_W'(SH_LIM_F))
        begin
            fs = th2_1;
            if (th3_1 >= -TH_W'(EL_LO_F) && th3_1 <= TH_W'(EL_HI_F))
                fe = th3_1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_x_next = st_x_reg;
        st_y_next = st_y_reg;
        st_z_next = st_z_reg;
        act_next  = act_reg;
        in_x_next = in_x_reg;
        in_y_next = in_y_reg;
        in_z_next = in_z_reg;
        ok_next   = ok_reg;
        acc_next  = acc_reg;
        rr_next   = rr_reg;
        den_next  = den_reg;
        c_next    = c_reg;
        s_next    = s_reg;
        r_next    = r_reg;
        by_next   = by_reg;
        bx_next   = bx_reg;
        idx_next  = idx_reg;
        ang_we    = 1'b0;
        ang_wdata = cor_angle;
        out_valid_next = out_valid_reg && !dout.ready;
        status_next = status_reg;
        jb_next = jb_reg;
        js_next = js_reg;
        je_next = je_reg;
        jw_next = jw_reg;
        ds_req  = '0;
        cor_req = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    act_next  = din.action;
                    in_x_next = din.target_x;
                    in_y_next = din.target_y;
                    in_z_next = din.target_z;
                    state_next = (din.action == ACT_TICK) ? ST_TXX : ST_SXX;
                end
            end
            ST_SXX: begin acc_next = AW'(prod); state_next = ST_SYY; end
            ST_SYY: begin acc_next = acc_reg + AW'(prod); state_next = ST_SZZ; end
            ST_SZZ: begin acc_next = acc_reg + AW'(prod); state_next = ST_SCMP; end
            ST_SCMP:
            begin
                ok_next = box_ok && (acc_reg <= AW'(prod));
                if (box_ok && (acc_reg <= AW'(prod)))
                begin
                    st_x_next = in_x_reg;
                    st_y_next = in_y_reg;
                    st_z_next = in_z_reg;
                end
                state_next = ST_OUT;
            end
            ST_TXX: begin acc_next = AW'(prod); state_next = ST_TYY; end
            ST_TYY:
            begin
                acc_next = acc_reg + AW'(prod);
                rr_next  = RES_W'(acc_reg + AW'(prod));
                state_next = ST_TZZ;
            end
            ST_TZZ: begin acc_next = acc_reg + AW'(prod); state_next = ST_TL1; end
            ST_TL1: begin acc_next = acc_reg - AW'(prod); state_next = ST_TL2; end
            ST_TL2: begin acc_next = acc_reg - AW'(prod); state_next = ST_TDEN; end
            ST_TDEN:
            begin
                den_next = DENW'({prod, 1'b0});
                state_next = ST_TCSEL;
            end
            ST_TCSEL:
            begin
                if (den_reg == '0)
                begin
                    c_next = acc_reg[AW-1] ? -CW'(ONE_F) : CW'(ONE_F);
                    state_next = ST_TCC;
                end
                else if (mag >= AW'(den_reg))
                begin
                    c_next = acc_reg[AW-1] ? -CW'(ONE_F) : CW'(ONE_F);
                    state_next = ST_TCC;
                end
                else
                begin
                    ds_req.start = 1'b1;
                    ds_req.mode  = DS_DIV;
                    ds_req.num   = (DS_W'(mag) << (FRAC_BITS + 1)) + DS_W'(den_reg);
                    ds_req.dvs   = DS_W'(den_reg) << 1;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (ds_done)
                begin
                    c_next = acc_reg[AW-1] ? -$signed(ds_result) : $signed(ds_result);
                    state_next = ST_TCC;
                end
            end
            ST_TCC:
            begin
                ds_req.start = 1'b1;
                ds_req.mode  = DS_SQRT;
                ds_req.num   = (DS_W'(1) << (2 * FRAC_BITS)) - DS_W'(prod);
                state_next = ST_TSQS;
            end
            ST_TSQS:
            begin
                if (ds_done)
                begin
                    s_next = ds_result[SW-1:0];
                    ds_req.start = 1'b1;
                    ds_req.mode  = DS_SQRT;
                    ds_req.num   = DS_W'(rr_reg);
                    state_next = ST_TSQR;
                end
            end
            ST_TSQR:
            begin
                if (ds_done)
                begin
                    r_next = ds_result;
                    state_next = ST_TBY;
                end
            end
            ST_TBY: begin by_next = CIN_W'(prod); state_next = ST_TBX; end
            ST_TBX:
            begin
                bx_next = $signed({{(CIN_W-LW-FRAC_BITS){1'b0}}, l1_reg, {FRAC_BITS{1'b0}}})
                        + CIN_W'(prod);
                idx_next = ANG_ALPHA;
                state_next = ST_TCST;
            end
            ST_TCST:
            begin
                cor_req.start = 1'b1;
                case (idx_reg)
                    ANG_ALPHA: begin cor_req.y = CIN_W'(zt); cor_req.x = $signed({{(CIN_W-RT_W){1'b0}}, r_reg}); end
                    ANG_BETA:  begin cor_req.y = by_reg; cor_req.x = bx_reg; end
                    ANG_T3:    begin cor_req.y = $signed({{(CIN_W-SW){1'b0}}, s_reg}); cor_req.x = CIN_W'(c_reg); end
                    default:   begin cor_req.y = CIN_W'(st_y_reg); cor_req.x = CIN_W'(st_x_reg); end
                endcase
                state_next = ST_TCW;
            end
            ST_TCW:
            begin
                if (cor_done)
                begin
                    ang_we = 1'b1;
                    if (idx_reg == ANG_BASE)
                        state_next = ST_OUT;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = ST_TCST;
                    end
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (act_reg == ACT_TICK)
                    begin
                        status_next = STAT_DONE;
                        jb_next = sat20(TH_W'(ang_reg[ANG_BASE]));
                        js_next = sat20(fs);
                        je_next = sat20(fe);
                        jw_next = sat20(-fs - fe);
                    end
                    else
                    begin
                        status_next = ok_reg ? STAT_ACCEPT : STAT_REJECT;
                        jb_next = '0;
                        js_next = '0;
                        je_next = '0;
                        jw_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= ANG_ALPHA;
            st_x_reg      <= '0;
            st_y_reg      <= '0;
            st_z_reg      <= RST_SZ;
            l1_reg        <= RST_L1;
            l2_reg        <= RST_L2;
            sh_reg        <= RST_SH;
            phi_reg       <= RST_PHI;
            rl_reg        <= RST_RL;
            hl_reg        <= RST_HL;
            zmin_reg      <= RST_ZMIN;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            st_x_reg      <= st_x_next;
            st_y_reg      <= st_y_next;
            st_z_reg      <= st_z_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_L1:   l1_reg   <= cfg_wdata[LW-1:0];
                    CFG_L2:   l2_reg   <= cfg_wdata[LW-1:0];
                    CFG_SH:   sh_reg   <= cfg_wdata[LW-1:0];
                    CFG_PHI:  phi_reg  <= cfg_wdata[LW-1:0];
                    CFG_RL:   rl_reg   <= cfg_wdata[LW-1:0];
                    CFG_HL:   hl_reg   <= cfg_wdata[LW-1:0];
                    CFG_ZMIN: zmin_reg <= $signed(cfg_wdata[XW-1:0]);
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        in_x_reg   <= in_x_next;
        in_y_reg   <= in_y_next;
        in_z_reg   <= in_z_next;
        ok_reg     <= ok_next;
        acc_reg    <= acc_next;
        rr_reg     <= rr_next;
        den_reg    <= den_next;
        c_reg      <= c_next;
        s_reg      <= s_next;
        r_reg      <= r_next;
        by_reg     <= by_next;
        bx_reg     <= bx_next;
        status_reg <= status_next;
        jb_reg     <= jb_next;
        js_reg     <= js_next;
        je_reg     <= je_next;
        jw_reg     <= jw_next;
        if (ang_we)
            ang_reg[idx_reg] <= ang_wdata;
    end

    assign din.ready           = (state_reg == ST_IDLE);
    assign dout.valid          = out_valid_reg;
    assign dout.status         = status_reg;
    assign dout.joint_base     = jb_reg;
    assign dout.joint_shoulder = js_reg;
    assign dout.joint_elbow    = je_reg;
    assign dout.joint_wrist    = jw_reg;

endmodule

// ===== sv/aik_checker.sv =====
module aik_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic signed [aik_pkg::JW-1:0] joint_base,
    input logic signed [aik_pkg::JW-1:0] joint_shoulder,
    input logic signed [aik_pkg::JW-1:0] joint_elbow,
    input logic signed [aik_pkg::JW-1:0] joint_wrist
);
    import aik_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input still ready after accepting a word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_DONE || status == STAT_ACCEPT ||
                       status == STAT_REJECT))
        else $error("unknown status code");

    a_set_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_DONE |-> joint_base == '0 && joint_shoulder == '0 &&
                                               joint_elbow == '0 && joint_wrist == '0)
        else $error("set-target result carries nonzero angles");

endmodule

bind arm_inverse_kinematics_core aik_checker u_aik_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .status         (dout.status),
    .joint_base     (dout.joint_base),
    .joint_shoulder (dout.joint_shoulder),
    .joint_elbow    (dout.joint_elbow),
    .joint_wrist    (dout.joint_wrist)
);

// ===== tb/sv/arm_inverse_kinematics_core_test.sv =====
`timescale 1ns / 100ps

module arm_inverse_kinematics_core_test;
    import aik_pkg::*;

    localparam longint ANGLE_PI    = 64'd3373259426;
    localparam longint ANGLE_HALF  = 64'd1686629713;
    localparam longint ANGLE_SHLIM = 64'd1686629362;
    localparam longint ANGLE_ELLO  = 64'd843314842;
    localparam longint ANGLE_ELHI  = 64'd3373259369;
    localparam longint UNIT        = 64'd1 << FRAC_BITS;
    localparam int     CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]           status;
        logic signed [JW-1:0] base_ang;
        logic signed [JW-1:0] shoulder_ang;
        logic signed [JW-1:0] elbow_ang;
        logic signed [JW-1:0] wrist_ang;
    } joint_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    aik_in_if  din();
    aik_out_if dout();

    arm_inverse_kinematics_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .dout      (dout),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    longint link_upper, link_fore, shoulder_off, phi_off, reach_max, horiz_max, z_floor;
    longint tgt_x, tgt_y, tgt_z;

    joint_word_t pending_joint_words[$];
    int  mismatches;
    int  cycle_count;
    int  sets_accepted, sets_rejected, ticks_done;
    int  stall_left;
    bit  quiet;

    always #5 clk = ~clk;

    function automatic longint angle_step(int i);
        longint steps[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
        if (i < 11)
            return steps[i];
        return (i <= 30) ? (64'sd1 << (30 - i)) : 0;
    endfunction

    function automatic longint to_frac(longint a);
        return (a + (64'sd1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    endfunction

    function automatic longint round_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        if (v > res)
            res++;
        return longint'(res);
    endfunction

    function automatic longint arc_tangent(longint yy, longint xx);
        longint base_a, acc, cx, cy, sx, sy;
        longint unsigned ux, uy, m;
        bit neg;
        base_a = 0;
        acc = 0;
        if (xx < 0)
        begin
            base_a = (yy >= 0) ? ANGLE_PI : -ANGLE_PI;
            xx = -xx;
            yy = -yy;
        end
        neg = yy < 0;
        ux = xx;
        uy = neg ? -yy : yy;
        if (ux == 0 && uy == 0)
            return to_frac(base_a);
        m = (ux > uy) ? ux : uy;
        while (m > (64'd1 << 30))
        begin
            ux >>= 1; uy >>= 1; m >>= 1;
        end
        while (m < (64'd1 << 29))
        begin
            ux <<= 1; uy <<= 1; m <<= 1;
        end
        cx = ux;
        cy = neg ? -longint'(uy) : longint'(uy);
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (cy == 0)
                break;
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy > 0)
            begin
                cx += sy; cy -= sx; acc += angle_step(i);
            end
            else
            begin
                cx -= sy; cy += sx; acc -= angle_step(i);
            end
        end
        return to_frac(base_a + acc);
    endfunction

    function automatic logic signed [JW-1:0] clamp_joint(longint v);
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return JW'(v);
    endfunction

    function automatic joint_word_t predict_joint_word(logic act, longint x, longint y,
                                                       longint z);
        joint_word_t w;
        longint zt, num, den, c, s, r, alpha, beta, t3, fs, fe;
        longint th2[2], th3[2];
        longint unsigned mag;
        w = '{default: 0};
        if (act == ACT_SET)
        begin
            if (x >= 0 && x <= horiz_max && y >= -horiz_max && y <= horiz_max &&
                z >= z_floor && z <= reach_max &&
                x * x + y * y + z * z <= reach_max * reach_max)
            begin
                tgt_x = x; tgt_y = y; tgt_z = z;
                w.status = STAT_ACCEPT;
                sets_accepted++;
            end
            else
            begin
                w.status = STAT_REJECT;
                sets_rejected++;
            end
            return w;
        end
        ticks_done++;
        zt = tgt_z - shoulder_off;
        num = tgt_x * tgt_x + tgt_y * tgt_y + zt * zt - link_upper * link_upper
              - link_fore * link_fore;
        den = 2 * link_upper * link_fore;
        if (den == 0)
            c = (num >= 0) ? UNIT : -UNIT;
        else
        begin
            mag = (num < 0) ? -num : num;
            if (mag >= den)
                c = (num < 0) ? -UNIT : UNIT;
            else
            begin
                mag = ((mag << (FRAC_BITS + 1)) + den) / (2 * den);
                c = (num < 0) ? -longint'(mag) : longint'(mag);
            end
        end
        s = round_sqrt((64'd1 << (2 * FRAC_BITS)) - c * c);
        r = round_sqrt(tgt_x * tgt_x + tgt_y * tgt_y);
        alpha = arc_tangent(zt, r);
        beta = arc_tangent(link_fore * s, link_upper * UNIT + link_fore * c);
        t3 = arc_tangent(s, c);
        th2[0] = to_frac(ANGLE_HALF) - (alpha - beta + phi_off);
        th2[1] = to_frac(ANGLE_HALF) - (alpha + beta + phi_off);
        th3[0] = phi_off - t3;
        th3[1] = phi_off + t3;
        fs = 0;
        fe = 0;
        for (int i = 0; i < 2; i++)
        begin
            if (th2[i] < -to_frac(ANGLE_SHLIM) || th2[i] > to_frac(ANGLE_SHLIM))
                continue;
            fs = th2[i];
            if (th3[i] < -to_frac(ANGLE_ELLO) || th3[i] > to_frac(ANGLE_ELHI))
                continue;
            fe = th3[i];
        end
        w.status = STAT_DONE;
        w.base_ang = clamp_joint(arc_tangent(tgt_y, tgt_x));
        w.shoulder_ang = clamp_joint(fs);
        w.elbow_ang = clamp_joint(fe);
        w.wrist_ang = clamp_joint(-fs - fe);
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        mismatches++;
    endtask

    task automatic send_word(logic act, longint x, longint y, longint z);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid <= 1'b1;
        din.action <= act;
        din.target_x <= XW'(x);
        din.target_y <= XW'(y);
        din.target_z <= XW'(z);
        do
            @(posedge clk);
        while (!din.ready);
        pending_joint_words.push_back(predict_joint_word(act,
                                       longint'($signed(XW'(x))),
                                       longint'($signed(XW'(y))),
                                       longint'($signed(XW'(z)))));
    endtask

    task automatic send_tick();
        send_word(ACT_TICK, $signed(XW'($urandom)), $signed(XW'($urandom)),
                  $signed(XW'($urandom)));
    endtask

    task automatic drain();
        din.valid <= 1'b0;
        @(posedge clk);
        while (pending_joint_words.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, longint value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DW'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_L1:   link_upper = value & 16'hFFFF;
            CFG_L2:   link_fore = value & 16'hFFFF;
            CFG_SH:   shoulder_off = value & 16'hFFFF;
            CFG_PHI:  phi_off = value & 16'hFFFF;
            CFG_RL:   reach_max = value & 16'hFFFF;
            CFG_HL:   horiz_max = value & 16'hFFFF;
            CFG_ZMIN: z_floor = longint'($signed(XW'(value)));
            default:  ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_plausible_target();
        longint x, y, z;
        x = $urandom_range(0, horiz_max);
        y = longint'($urandom_range(0, 2 * horiz_max)) - horiz_max;
        z = z_floor + longint'($urandom_range(0, int'(reach_max - z_floor)));
        send_word(ACT_SET, x, y, z);
    endtask

    task automatic test_reset_state();
        send_tick();
        send_word(ACT_SET, 0, 0, shoulder_off);
        send_tick();
        send_word(ACT_SET, 0, 0, reach_max);
        send_tick();
        drain();
    endtask

    task automatic test_target_bounds();
        send_word(ACT_SET, -65536, 0, 0);
        send_word(ACT_SET, 65535, -65536, 65535);
        send_word(ACT_SET, 0, 65535, -65536);
        send_word(ACT_SET, horiz_max, 0, 0);
        send_word(ACT_SET, horiz_max + 1, 0, 0);
        send_word(ACT_SET, 0, -horiz_max, 0);
        send_word(ACT_SET, 0, -horiz_max - 1, 0);
        send_word(ACT_SET, 0, 0, z_floor);
        send_word(ACT_SET, 0, 0, z_floor - 1);
        send_word(ACT_SET, 0, 0, reach_max + 1);
        send_word(ACT_SET, 20000, 15000, 9000);
        send_tick();
        send_word(ACT_SET, 1, 0, 0);
        send_tick();
        send_word(ACT_SET, 6000, -2000, 4000);
        send_tick();
        drain();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_L1, 0);
        send_tick();
        drain();
        write_reg(CFG_L1, 65535);
        write_reg(CFG_L2, 65535);
        write_reg(CFG_SH, 65535);
        write_reg(CFG_PHI, 65535);
        write_reg(CFG_RL, 65535);
        write_reg(CFG_HL, 65535);
        write_reg(CFG_ZMIN, -65536);
        send_word(ACT_SET, 65535, -65535, -65536);
        send_word(ACT_SET, 40000, -30000, -20000);
        send_tick();
        send_word(ACT_SET, 0, 0, 0);
        send_tick();
        drain();
        write_reg(CFG_L2, 17'h10000);
        write_reg(CFG_PHI, 0);
        write_reg(CFG_SH, 0);
        write_reg(CFG_RL, 0);
        write_reg(CFG_HL, 0);
        write_reg(CFG_ZMIN, 0);
        write_reg(CFG_AW'(CFG_ZMIN + 1), 12345);
        send_word(ACT_SET, 0, 0, 0);
        send_word(ACT_SET, 0, 0, 1);
        send_tick();
        drain();
    endtask

    task automatic test_random_motion(int count);
        int sent, r, n_ticks;
        sent = 0;
        for (int phase = 0; sent < count; phase++)
        begin
            if (phase % 2 == 0)
            begin
                write_reg(CFG_L1, 8000 + $urandom_range(0, 20000));
                write_reg(CFG_L2, 8000 + $urandom_range(0, 20000));
                write_reg(CFG_SH, $urandom_range(0, 8000));
                write_reg(CFG_PHI, $urandom_range(0, 20000));
                write_reg(CFG_RL, 20000 + $urandom_range(0, 45535));
                write_reg(CFG_HL, 15000 + $urandom_range(0, 50535));
                write_reg(CFG_ZMIN, -longint'($urandom_range(0, 65536)));
            end
            else
            begin
                write_reg(CFG_L1, $urandom_range(0, 65535));
                write_reg(CFG_L2, $urandom_range(0, 65535));
                write_reg(CFG_SH, $urandom_range(0, 65535));
                write_reg(CFG_PHI, $urandom_range(0, 65535));
                write_reg(CFG_RL, $urandom_range(0, 65535));
                write_reg(CFG_HL, $urandom_range(0, 65535));
                write_reg(CFG_ZMIN, -longint'($urandom_range(0, 65536)));
            end
            quiet = (phase % 3 == 2);
            for (int k = 0; k < 110 && sent < count; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    n_ticks = $urandom_range(1, 3);
                    send_plausible_target();
                    repeat (n_ticks) send_tick();
                    sent += 1 + n_ticks;
                end
                else if (r < 90)
                begin
                    send_word(ACT_SET, $signed(XW'($urandom)), $signed(XW'($urandom)),
                              $signed(XW'($urandom)));
                    sent++;
                end
                else
                begin
                    send_tick();
                    sent++;
                end
            end
            quiet = 0;
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || quiet)
            dout.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            dout.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 20)
        begin
            dout.ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
        else
            dout.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        joint_word_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            if (pending_joint_words.size() == 0)
            begin
                $display("UNEXPECTED word at cycle %0d", cycle_count);
                mismatches++;
            end
            else
            begin
                want = pending_joint_words.pop_front();
                if (dout.status !== want.status)
                    report_mismatch("status", dout.status, want.status);
                if (dout.joint_base !== want.base_ang)
                    report_mismatch("joint_base", dout.joint_base, want.base_ang);
                if (dout.joint_shoulder !== want.shoulder_ang)
                    report_mismatch("joint_shoulder", dout.joint_shoulder,
                                    want.shoulder_ang);
                if (dout.joint_elbow !== want.elbow_ang)
                    report_mismatch("joint_elbow", dout.joint_elbow, want.elbow_ang);
                if (dout.joint_wrist !== want.wrist_ang)
                    report_mismatch("joint_wrist", dout.joint_wrist, want.wrist_ang);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout with %0d words outstanding", pending_joint_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        din.valid = 0;
        din.action = ACT_SET;
        din.target_x = '0;
        din.target_y = '0;
        din.target_z = '0;
        dout.ready = 0;
        mismatches = 0;
        cycle_count = 0;
        stall_left = 0;
        quiet = 0;
        sets_accepted = 0;
        sets_rejected = 0;
        ticks_done = 0;
        link_upper = 15644;
        link_fore = 14155;
        shoulder_off = 2488;
        phi_off = 8258;
        reach_max = 32113;
        horiz_max = 26214;
        z_floor = -11667;
        tgt_x = 0;
        tgt_y = 0;
        tgt_z = 32162;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_target_bounds();
        test_register_extremes();
        test_random_motion(810);

        drain();
        $display("Covered %0d accepted and %0d rejected targets, %0d joint solutions",
                 sets_accepted, sets_rejected, ticks_done);
        if (mismatches == 0 && pending_joint_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/aik_pkg.sv
sv/aik_if.sv
sv/aik_divsqrt.sv
sv/aik_cordic.sv
sv/arm_inverse_kinematics_core.sv
sv/aik_checker.sv
tb/sv/arm_inverse_kinematics_core_test.sv
